// ===== design/lzfw_pkg.sv =====
// Shared constants and helpers for the flag-window LZ decompressor.
// No dependencies; imported by lz_flag_window_decompressor.
`default_nettype none

package lzfw_pkg;

   // History window
   localparam int WIN_BYTES = 1024;
   localparam int PTR_W     = $clog2(WIN_BYTES);
   localparam int BANK_W    = PTR_W - 1;
   localparam int BANK_DEPTH = WIN_BYTES / 2;
   // Byte count saturates at the window size, so it needs one more bit
   localparam int CNT_W     = PTR_W + 1;
   localparam int DIST_W    = PTR_W + 1;

   // Pair token layout: 6-bit count field above a 10-bit offset
   localparam int LEN_FIELD_W = 16 - PTR_W;
   localparam int REM_W       = LEN_FIELD_W + 1;
   localparam int MIN_MATCH   = 2;

   // Flag shifter: remaining flag bits with a marker bit above them
   localparam int FLAG_W = 9;
   localparam logic [FLAG_W-1:0] FLAG_EMPTY = 9'h001;

   localparam logic [7:0] BYTE_ZERO = 8'h00;

   typedef logic [7:0] byte_type;

   function automatic logic [7:0] reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/lz_flag_window_decompressor.sv =====
// Flag-byte LZ decompressor with a 1 KiB history window held in two byte banks.
// Depends on lzfw_pkg for window constants and the bit reversal helper.
//
// Usage:
//   req_* takes the compressed stream, one byte per item; req_tlast marks the
//   last byte of a stream, after which the parser and window start over.
//   rsp_* returns decompressed bytes two per item: tdata holds the first byte
//   in [7:0] and the second in [15:8]; tuser says the second byte is valid;
//   tlast marks the final item caused by one input byte.
// Timing:
//   A flag byte or the first byte of a pair gives no item.
//   A literal's item appears in the next cycle.
//   For a pair's second byte the copy loop moves two bytes a cycle while the
//   output is not stalled, one through each history bank, each bank with one
//   read and one write port. Results pass through the copy state and then the
//   output register. No new input is taken while a copy runs.
// Reset:
//   Clears the parser, write pointer and byte count. The history banks are not
//   cleared; the byte count gates reads so unwritten history reads as zero,
//   so there is no clearing pass and the block is ready right after reset.
// Backpressure:
//   A one-item output register decouples the sides; while rsp_tready is low
//   with an item waiting, the copy loop holds and re-reads its current source.
`default_nettype none

module lz_flag_window_decompressor
   import lzfw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: [7:0] in_byte
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: [7:0] first_byte, [15:8] second_byte
   output logic [15:0]      rsp_tdata,
   // rsp_tuser: [0] second_valid
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_COPY = 1'b1;

   // History banks: even and odd byte positions
   byte_type mem_even [0:BANK_DEPTH-1];
   byte_type mem_odd  [0:BANK_DEPTH-1];
   byte_type rd_even_ff, rd_odd_ff;

   logic                  state_ff, state_in;
   logic [PTR_W-1:0]      wp_ff, wp_in;
   logic [CNT_W-1:0]      bp_ff, bp_in;
   logic [FLAG_W-1:0]     flag_ff, flag_in;
   logic                  phase_ff, phase_in;
   byte_type              held_ff, held_in;
   byte_type              l1_ff, l1_in;
   byte_type              l2_ff, l2_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [PTR_W-1:0]      src_ff, src_in;
   logic                  eos_ff, eos_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   byte_type              rsp_first_ff, rsp_first_in;
   byte_type              rsp_second_ff, rsp_second_in;
   logic                  rsp_sv_ff, rsp_sv_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  advance, accept, do_reset;
   logic                  emit_en, emit_two, emit_last;
   byte_type              e0, e1;

   logic [PTR_W-1:0]      ra, ra_up, wa_up;
   logic [BANK_W-1:0]     ra_even, ra_odd, wa_even, wa_odd;
   logic                  we_even, we_odd;
   byte_type              wd_even, wd_odd;

   // Copy datapath
   byte_type              m0, m1, b0, b1;
   logic [CNT_W:0]        bp_p1;
   logic                  gate0, gate1, done;
   logic [CNT_W:0]        bp_sum;

   // Pair decode from the incoming high byte
   logic [REM_W-1:0]      pair_count;
   logic [PTR_W-1:0]      pair_offset;

   always_comb begin
      pair_count  = {1'b0, req_tdata[7:PTR_W-8]} + REM_W'(MIN_MATCH);
      pair_offset = {req_tdata[PTR_W-9:0], held_ff};

      m0 = src_ff[0] ? rd_odd_ff  : rd_even_ff;
      m1 = src_ff[0] ? rd_even_ff : rd_odd_ff;
      bp_p1 = {1'b0, bp_ff} + (CNT_W + 1)'(1);
      gate0 = dist_ff <= bp_ff;
      gate1 = {1'b0, dist_ff} <= bp_p1;
      done  = rem_ff <= REM_W'(2);

      // Forward the two most recent bytes, which the bank read may not see yet
      if (!gate0) begin
         b0 = BYTE_ZERO;
      end else if (dist_ff == DIST_W'(1)) begin
         b0 = l1_ff;
      end else if (dist_ff == DIST_W'(2)) begin
         b0 = l2_ff;
      end else begin
         b0 = m0;
      end
      if (!gate1) begin
         b1 = BYTE_ZERO;
      end else if (dist_ff == DIST_W'(1)) begin
         b1 = b0;
      end else if (dist_ff == DIST_W'(2)) begin
         b1 = l1_ff;
      end else if (dist_ff == DIST_W'(3)) begin
         b1 = l2_ff;
      end else begin
         b1 = m1;
      end
   end

   always_comb begin
      advance    = !rsp_valid_ff || rsp_tready;
      req_tready = (state_ff == ST_IDLE) && advance;
      accept     = req_tvalid && req_tready;

      state_in = state_ff;
      wp_in    = wp_ff;
      bp_in    = bp_ff;
      flag_in  = flag_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      l1_in    = l1_ff;
      l2_in    = l2_ff;
      rem_in   = rem_ff;
      dist_in  = dist_ff;
      src_in   = src_ff;
      eos_in   = eos_ff;
      do_reset = 1'b0;
      emit_en   = 1'b0;
      emit_two  = 1'b0;
      emit_last = 1'b0;
      e0 = b0;
      e1 = b1;
      ra = src_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (phase_ff) begin
                  // Prime the bank read for the first pair of the copy
                  ra       = wp_ff + pair_offset;
                  src_in   = wp_ff + pair_offset;
                  dist_in  = DIST_W'(WIN_BYTES) - {1'b0, pair_offset};
                  rem_in   = pair_count;
                  eos_in   = req_tlast;
                  state_in = ST_COPY;
                  phase_in = 1'b0;
                  flag_in  = flag_ff >> 1;
               end else if (flag_ff == FLAG_EMPTY) begin
                  flag_in  = {1'b1, reverse8(req_tdata)};
                  do_reset = req_tlast;
               end else if (flag_ff[0]) begin
                  emit_en   = 1'b1;
                  emit_last = 1'b1;
                  e0        = req_tdata;
                  flag_in   = flag_ff >> 1;
                  do_reset  = req_tlast;
               end else begin
                  held_in  = req_tdata;
                  phase_in = 1'b1;
                  do_reset = req_tlast;
               end
            end
         end
         ST_COPY: begin
            // Re-read the same source while stalled
            ra = advance ? src_ff + PTR_W'(2) : src_ff;
            if (advance) begin
               emit_en   = 1'b1;
               emit_two  = !(rem_ff == REM_W'(1));
               emit_last = done;
               src_in    = src_ff + PTR_W'(2);
               rem_in    = rem_ff - REM_W'(2);
               if (done) begin
                  state_in = ST_IDLE;
                  do_reset = eos_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Commit emitted bytes to pointer, count and recent-byte registers
      bp_sum = {1'b0, bp_ff} + (emit_two ? (CNT_W + 1)'(2) : (CNT_W + 1)'(1));
      if (emit_en) begin
         wp_in = wp_ff + (emit_two ? PTR_W'(2) : PTR_W'(1));
         bp_in = (bp_sum > (CNT_W + 1)'(WIN_BYTES)) ? CNT_W'(WIN_BYTES)
                                                   : bp_sum[CNT_W-1:0];
         if (emit_two) begin
            l2_in = e0;
            l1_in = e1;
         end else begin
            l2_in = l1_ff;
            l1_in = e0;
         end
      end

      if (do_reset) begin
         wp_in    = '0;
         bp_in    = '0;
         flag_in  = FLAG_EMPTY;
         phase_in = 1'b0;
         held_in  = BYTE_ZERO;
      end

      // Bank write: byte e0 at wp, e1 at wp + 1
      wa_up   = wp_ff + {{(PTR_W-1){1'b0}}, wp_ff[0]};
      wa_even = wa_up[PTR_W-1:1];
      wa_odd  = wp_ff[PTR_W-1:1];
      we_even = emit_en && (wp_ff[0] ? emit_two : 1'b1);
      we_odd  = emit_en && (wp_ff[0] ? 1'b1 : emit_two);
      wd_even = wp_ff[0] ? e1 : e0;
      wd_odd  = wp_ff[0] ? e0 : e1;

      // Bank read: byte at ra and ra + 1
      ra_up   = ra + {{(PTR_W-1){1'b0}}, ra[0]};
      ra_even = ra_up[PTR_W-1:1];
      ra_odd  = ra[PTR_W-1:1];

      if (emit_en) begin
         rsp_valid_in  = 1'b1;
         rsp_first_in  = e0;
         rsp_second_in = emit_two ? e1 : BYTE_ZERO;
         rsp_sv_in     = emit_two;
         rsp_last_in   = emit_last;
      end else begin
         rsp_valid_in  = rsp_valid_ff && !rsp_tready;
         rsp_first_in  = rsp_first_ff;
         rsp_second_in = rsp_second_ff;
         rsp_sv_in     = rsp_sv_ff;
         rsp_last_in   = rsp_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we_even) begin
         mem_even[wa_even] <= wd_even;
      end
      rd_even_ff <= mem_even[ra_even];
   end

   always_ff @(posedge clock) begin
      if (we_odd) begin
         mem_odd[wa_odd] <= wd_odd;
      end
      rd_odd_ff <= mem_odd[ra_odd];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         bp_ff        <= '0;
         flag_ff      <= FLAG_EMPTY;
         phase_ff     <= 1'b0;
         held_ff      <= BYTE_ZERO;
         eos_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         bp_ff        <= bp_in;
         flag_ff      <= flag_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         eos_ff       <= eos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l1_ff         <= l1_in;
      l2_ff         <= l2_in;
      rem_ff        <= rem_in;
      dist_ff       <= dist_in;
      src_ff        <= src_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_sv_ff     <= rsp_sv_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_second_ff, rsp_first_ff};
   assign rsp_tuser  = rsp_sv_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
